### design/quadratic_root_solver_core_defines.svh
// Assertion macros shared by the solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH

// Checks that an implication holds on every clock edge outside reset.
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds on the next clock edge after an antecedent.
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/qrs_pkg.sv
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int unsigned ROOT_WIDTH = 34;
  localparam int unsigned KIND_WIDTH = 3;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_INFINITE = 3'd0,
    KIND_NONE     = 3'd1,
    KIND_LINEAR   = 3'd2,
    KIND_COMPLEX  = 3'd3,
    KIND_TWO_REAL = 3'd4,
    KIND_DOUBLE   = 3'd5
  } kind_t;

  typedef logic signed [ROOT_WIDTH-1:0] root_t;
endpackage

### design/qrs_if.sv
`timescale 1ns / 1ps
interface qrs_in_if #(parameter int COEF_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;
  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_out_if;
  logic valid;
  logic ready;
  logic [2:0] solution_kind;
  logic signed [33:0] first_root;
  logic signed [33:0] second_root;
  modport source (output valid, output solution_kind, output first_root,
                  output second_root, input ready);
  modport sink (input valid, input solution_kind, input first_root,
                input second_root, output ready);
endinterface

### design/quadratic_root_solver_core.sv
`timescale 1ns / 1ps
// Pipeline: three setup stages, one stage per square-root bit and one per quotient bit
// lie between an accepted transaction and its result valid.
// Throughput: one transaction per cycle unless the output stalls; each stage of the square
// root and the two dividers is its own register rank, so a new triple enters every cycle.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, rst_n low) clears all valid bits; data registers are not reset.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input logic clk,
  input logic rst_n,
  qrs_in_if.sink   in_ch,
  qrs_out_if.source out_ch
);
  import qrs_pkg::*;
  `include "quadratic_root_solver_core_defines.svh"

  localparam int DW   = 2 * COEF_WIDTH + 2;            // delta width
  localparam int SQB  = COEF_WIDTH + 1 + FRAC_BITS;     // root bits of sqrt
  localparam int SQS  = (DW + 2 * FRAC_BITS + 1) / 2;   // sqrt iterations
  localparam int NW   = COEF_WIDTH + FRAC_BITS + 3;     // numerator magnitude width
  localparam int QW   = NW + 1;                         // quotient width
  localparam int DVW  = COEF_WIDTH + 2;                 // divisor magnitude width
  localparam int NST  = 3 + SQS + QW;                   // total stages
  localparam logic [QW-1:0] RMAX = QW'((64'd1 << (ROOT_WIDTH - 1)) - 64'd1);

  typedef struct packed {
    logic [2:0] kind;
    logic signed [COEF_WIDTH-1:0] a, b, c;
    logic signed [DW-1:0] delta;
    logic [DW+2*FRAC_BITS:0] rad;
    logic [SQB:0] rt;
    logic [SQB+2:0] rem;
    logic [NW-1:0] n1, n2;
    logic [DVW-1:0] dv;
    logic s1, s2;
    logic [NW:0] r1, r2;
    logic [QW-1:0] q1, q2;
  } st_t;

  st_t  pipe_r [NST];
  logic vld_r  [NST];
  logic adv;

  assign adv         = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;

  function automatic logic [QW-1:0] rnd(input logic [QW-1:0] q, input logic [NW:0] r,
                                        input logic [DVW-1:0] d);
    rnd = ({r, 1'b0} >= {1'b0, d}) ? q + 1'b1 : q;
  endfunction

  function automatic root_t sat(input logic [QW-1:0] q, input logic neg);
    logic [QW-1:0] m;
    m = (q > RMAX) ? RMAX + QW'(neg) : q;
    sat = neg ? -root_t'(m) : root_t'(m);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < NST; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_t s;
      // Stage 0: capture the coefficients.
      s = '0;
      s.a = in_ch.coef_a; s.b = in_ch.coef_b; s.c = in_ch.coef_c;
      pipe_r[0] <= s;
      // Stage 1: discriminant products.
      s = pipe_r[0];
      s.delta = DW'(s.b * s.b) - DW'(4 * s.a * s.c);
      pipe_r[1] <= s;
      // Stage 2: kind, divisor and radicand setup.
      s = pipe_r[1];
      if (s.a == 0) begin
        s.kind = (s.b == 0) ? ((s.c == 0) ? KIND_INFINITE : KIND_NONE) : KIND_LINEAR;
        s.dv = DVW'(s.b < 0 ? -$signed({s.b[COEF_WIDTH-1], s.b}) : s.b);
      end else begin
        s.kind = s.delta[DW-1] ? KIND_COMPLEX : ((s.delta == 0) ? KIND_DOUBLE : KIND_TWO_REAL);
        s.dv = DVW'(s.a < 0 ? -$signed({s.a, 1'b0}) : $signed({s.a, 1'b0}));
      end
      s.rad = {s.delta, {2*FRAC_BITS{1'b0}}, 1'b0} >> 1;
      s.rt = '0; s.rem = '0;
      pipe_r[2] <= s;
      // Square root stages.
      for (int k = 0; k < SQS; k++) begin
        logic [SQB+2:0] rm, tr;
        s = pipe_r[2+k];
        rm = {s.rem[SQB:0], s.rad[2*SQS-1-2*k -: 2]};
        tr = {s.rt, 2'b01};
        if (rm >= tr) begin
          s.rem = rm - tr; s.rt = {s.rt[SQB-1:0], 1'b1};
        end else begin
          s.rem = rm; s.rt = {s.rt[SQB-1:0], 1'b0};
        end
        if (k == SQS - 1) begin
          logic signed [NW:0] nb, sq, x1, x2;
          nb = (s.a == 0) ? -((NW+1)'(s.c) <<< FRAC_BITS) : -((NW+1)'(s.b) <<< FRAC_BITS);
          sq = (s.kind == KIND_TWO_REAL) ? (NW+1)'(s.rt) : '0;
          x1 = nb - sq; x2 = nb + sq;
          s.s1 = x1[NW] ^ ((s.a == 0) ? s.b[COEF_WIDTH-1] : s.a[COEF_WIDTH-1]);
          s.s2 = x2[NW] ^ s.a[COEF_WIDTH-1];
          s.n1 = NW'(x1[NW] ? -x1 : x1);
          s.n2 = NW'(x2[NW] ? -x2 : x2);
          s.r1 = '0; s.r2 = '0; s.q1 = '0; s.q2 = '0;
        end
        pipe_r[3+k] <= s;
      end
      // Division stages, one quotient bit each, both roots in parallel.
      for (int j = 0; j < QW; j++) begin
        logic [NW+1:0] t1, t2;
        s = pipe_r[3+SQS-1+j];
        t1 = {s.r1, (j == 0) ? 1'b0 : s.n1[QW-1-j]};
        t2 = {s.r2, (j == 0) ? 1'b0 : s.n2[QW-1-j]};
        s.q1 = {s.q1[QW-2:0], t1 >= {2'b0, s.dv}};
        s.q2 = {s.q2[QW-2:0], t2 >= {2'b0, s.dv}};
        s.r1 = (NW+1)'((t1 >= {2'b0, s.dv}) ? t1 - {2'b0, s.dv} : t1);
        s.r2 = (NW+1)'((t2 >= {2'b0, s.dv}) ? t2 - {2'b0, s.dv} : t2);
        pipe_r[3+SQS+j] <= s;
      end
    end
  end

  root_t r1, r2;
  st_t   fin;
  assign fin = pipe_r[NST-1];
  always_comb begin
    root_t x1, x2;
    x1 = sat(rnd(fin.q1, fin.r1, fin.dv), fin.s1);
    x2 = sat(rnd(fin.q2, fin.r2, fin.dv), fin.s2);
    r1 = '0; r2 = '0;
    unique case (fin.kind)
      KIND_LINEAR, KIND_DOUBLE: r1 = x1;
      KIND_TWO_REAL: begin
        r1 = (x1 > x2) ? x2 : x1;
        r2 = (x1 > x2) ? x1 : x2;
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = vld_r[NST-1];
  assign out_ch.solution_kind = fin.kind;
  assign out_ch.first_root    = r1;
  assign out_ch.second_root   = r2;

  `QRS_ASSERT_IMP(a_order, clk, rst_n, out_ch.valid && fin.kind == KIND_TWO_REAL, r1 <= r2, "roots out of order")
  `QRS_ASSERT_IMP(a_kind, clk, rst_n, out_ch.valid, fin.kind <= KIND_DOUBLE, "bad kind")
  `QRS_ASSERT_NEXT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.first_root), "stalled result moved")
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import qrs_pkg::*;

  localparam int COEF_W = 16;
  localparam int FRAC_W = 16;
  localparam longint ROOT_HI = (64'sd1 <<< (ROOT_WIDTH - 1)) - 1;
  localparam longint ROOT_LO = -ROOT_HI - 1;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    kind_t kind;
    root_t first;
    root_t second;
  } roots_t;

  function automatic logic [63:0] sqrt_scaled(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] pair;
    logic [63:0] trial;
    rem = 0;
    root = 0;
    for (int i = 31 + FRAC_W; i >= 0; i--) begin
      pair = (i >= FRAC_W) ? ((v >> (2 * (i - FRAC_W))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint div_round_sat(longint n, longint d);
    logic [63:0] un;
    logic [63:0] ud;
    logic [63:0] q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    if ((n < 0) != (d < 0)) return (q > ROOT_HI) ? ROOT_LO : -longint'(q);
    return (q > ROOT_HI) ? ROOT_HI : longint'(q);
  endfunction

  function automatic roots_t solve_quadratic(logic signed [COEF_W-1:0] ca,
                                             logic signed [COEF_W-1:0] cb,
                                             logic signed [COEF_W-1:0] cc);
    roots_t res;
    longint a;
    longint b;
    longint c;
    longint scale;
    longint disc;
    longint s;
    longint r1;
    longint r2;
    longint t;
    a = ca;
    b = cb;
    c = cc;
    scale = 64'sd1 <<< FRAC_W;
    r1 = 0;
    r2 = 0;
    if (a == 0) begin
      if (b == 0) begin
        res.kind = (c == 0) ? KIND_INFINITE : KIND_NONE;
      end else begin
        res.kind = KIND_LINEAR;
        r1 = div_round_sat(-c * scale, b);
      end
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        res.kind = KIND_COMPLEX;
      end else if (disc == 0) begin
        res.kind = KIND_DOUBLE;
        r1 = div_round_sat(-b * scale, 2 * a);
      end else begin
        res.kind = KIND_TWO_REAL;
        s = longint'(sqrt_scaled(disc));
        r1 = div_round_sat(-b * scale - s, 2 * a);
        r2 = div_round_sat(-b * scale + s, 2 * a);
        if (r1 > r2) begin
          t = r1;
          r1 = r2;
          r2 = t;
        end
      end
    end
    res.first = root_t'(r1);
    res.second = root_t'(r2);
    return res;
  endfunction

  class root_scoreboard;
    roots_t pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned kind_seen[6];

    function void note_input(logic signed [COEF_W-1:0] a, logic signed [COEF_W-1:0] b,
                             logic signed [COEF_W-1:0] c);
      pending.push_back(solve_quadratic(a, b, c));
    endfunction

    function void check_result(logic [2:0] kind, root_t first, root_t second);
      roots_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: kind %0d", kind);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (exp_r.kind <= KIND_DOUBLE) kind_seen[exp_r.kind]++;
      if (kind !== exp_r.kind || first !== exp_r.first || second !== exp_r.second) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected kind %0d roots %0d %0d, got kind %0d roots %0d %0d",
                   exp_r.kind, exp_r.first, exp_r.second, kind, first, second);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int send_idle;
  int recv_idle;
  int stall_cycles;
  root_scoreboard sb;

  qrs_in_if #(.COEF_WIDTH(COEF_W)) in_ch ();
  qrs_out_if out_ch ();

  quadratic_root_solver_core #(.COEF_WIDTH(COEF_W), .FRAC_BITS(FRAC_W)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.coef_a, in_ch.coef_b, in_ch.coef_c);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.solution_kind, out_ch.first_root, out_ch.second_root);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_coefs(int a, int b, int c);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.coef_a = COEF_W'(a);
    in_ch.coef_b = COEF_W'(b);
    in_ch.coef_c = COEF_W'(c);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_item();
    int p1;
    int p2;
    int q1;
    int q2;
    int r;
    p1 = $urandom_range(1, 40) * ($urandom_range(1) ? 1 : -1);
    p2 = $urandom_range(1, 40);
    q1 = int'($urandom_range(80)) - 40;
    q2 = int'($urandom_range(80)) - 40;
    r = $urandom_range(1, 8) * ($urandom_range(1) ? 1 : -1);
    case ($urandom_range(5))
      0: send_coefs(r * p1 * p2, r * (p1 * q2 + p2 * q1), r * q1 * q2);
      1: send_coefs(r * p1 * p1, 2 * r * p1 * q1, r * q1 * q1);
      2: send_coefs(0, $urandom_range(3) == 0 ? 0 : $urandom, $urandom);
      3: send_coefs(int'($urandom_range(200)) - 100, int'($urandom_range(2000)) - 1000,
                    int'($urandom_range(200)) - 100);
      default: send_coefs($urandom, $urandom, $urandom);
    endcase
  endtask

  initial begin
    sb = new();
    stall_cycles = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    send_coefs(0, 0, 0);
    send_coefs(0, 0, 5);
    send_coefs(0, 0, -32768);
    send_coefs(0, 3, -7);
    send_coefs(0, -32768, 32767);
    send_coefs(0, 1, -32768);
    send_coefs(0, -1, -32768);
    send_coefs(0, 3, 1);
    send_coefs(1, 0, 1);
    send_coefs(1, -3, 2);
    send_coefs(-1, 3, -2);
    send_coefs(1, 2, 1);
    send_coefs(-4, 4, -1);
    send_coefs(3, 1, -2);
    send_coefs(1, -32768, 0);
    send_coefs(32767, -32768, -32768);
    send_coefs(-32768, -32768, -32768);
    send_coefs(-32768, 32767, 32767);
    send_coefs(1, 32767, -32768);
    send_coefs(-32768, 0, 32767);
    send_coefs(32767, 32767, 32767);
    send_coefs(-1, -1, -1);
    send_coefs(2, 5, 3);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 23 : (phase == 1) ? 45 : 0;
      recv_idle = (phase == 0) ? 45 : (phase == 1) ? 23 : 0;
      for (int n = 0; n < 200; n++) send_random_item();
      if (phase == 1) wait_drained();
    end
    send_idle = 0;
    wait_drained();

    $display("Checked %0d results: infinite %0d, none %0d, linear %0d, complex %0d,",
             sb.checked, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3]);
    $display("two real roots %0d, double root %0d; %0d mismatches.",
             sb.kind_seen[4], sb.kind_seen[5], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
